// ===== hdl/sbo_pkg.sv =====
// Shared constants and types for the segment versus box occlusion test.
package sbo_pkg;

   // Box table depth and the widths that follow from it.
   localparam int MAX_BOXES = 4096;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = IDX_W + 1;

   // Fixed Q23.8 coordinate field width and derived arithmetic widths.
   localparam int COORD_W    = 32;
   localparam int NUM_AXES   = 3;
   localparam int REQ_DATA_W = 6 * COORD_W;
   localparam int RSP_DATA_W = 8;
   localparam int DIFF_W     = COORD_W + 1;       // b - a
   localparam int DMAG_W     = COORD_W;           // |b - a| fits in 32 bits
   localparam int EDGE_W     = COORD_W + 2;       // c - h - a and c + h - a
   localparam int EMAG_W     = EDGE_W - 1;        // magnitude of an edge offset
   localparam int FRAC_SH    = 16;                // Q0.16 fractions
   localparam int NUM_W      = EMAG_W + FRAC_SH;  // dividend magnitude
   localparam int QUOT_W     = NUM_W + 1;         // signed quotient
   localparam int DSTEP_W    = $clog2(NUM_W + 1);

   // Configuration register widths and reset values.
   localparam int MD_W   = 31;
   localparam int FRAC_W = 17;
   localparam int CSR_W  = MD_W;
   localparam logic [MD_W-1:0]   MIN_DIST_RST = MD_W'(256);
   localparam logic [FRAC_W-1:0] NEAR_RST     = FRAC_W'(655);
   localparam logic [FRAC_W-1:0] FAR_RST      = FRAC_W'(64881);

   // Item kinds carried on the request user sideband.
   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_ADD   = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MIN_DIST = 2'd0,
      CSR_NEAR     = 2'd1,
      CSR_FAR      = 2'd2
   } csr_index_type;

   // One stored box: center and half size per axis.
   typedef struct packed {
      logic [NUM_AXES-1:0][COORD_W-1:0] half;
      logic [NUM_AXES-1:0][COORD_W-1:0] center;
   } box_type;

endpackage

// ===== hdl/segment_box_occlusion_test.sv =====
// Top level of the segment versus axis-aligned box occlusion test.
//
// Items arrive on the req_ channel: req_tuser gives the kind (clear, add box,
// query) and req_tdata the two points. A clear or an add produces no transfer
// on rsp_. A query produces one rsp_ transfer whose bit 0 is the hit flag. The
// block takes one item at a time; req_tready is low while a query is being
// worked on or its answer waits.
// A query is registered on entry and goes through the length test; unless the
// segment is short or the table empty, it then scans the stored boxes in order
// through one shared radix-2 divider. Each box costs a table read and a final
// check plus, per non-parallel axis, a setup step and two divisions; a parallel
// axis is decided in its setup step. The scan stops at the first hit.
// Synchronous reset empties the table, restores the csr_ registers and
// drops rsp_tvalid. When the receiver stalls, the answer stays on rsp_ and
// no new item is taken until it is transferred.
module segment_box_occlusion_test (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit up, 32 bits each
   input  logic [sbo_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // hit in bit 0, the rest zero
   output logic [sbo_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [sbo_pkg::CSR_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEN,
      ST_BOX_RD,
      ST_AXIS,
      ST_DIV,
      ST_DIV_END,
      ST_BOX_END,
      ST_RESP
   } state_type;

   localparam int AXIS_W = $clog2(sbo_pkg::NUM_AXES);

   state_type state_ff;

   // Configuration registers.
   logic [sbo_pkg::MD_W-1:0]   min_dist_ff;
   logic [sbo_pkg::FRAC_W-1:0] near_ff;
   logic [sbo_pkg::FRAC_W-1:0] far_ff;

   // Box table and its fill count.
   sbo_pkg::box_type            box_mem [sbo_pkg::MAX_BOXES];
   sbo_pkg::box_type            rd_ff;
   logic [sbo_pkg::CNT_W-1:0]   count_ff;
   logic [sbo_pkg::IDX_W-1:0]   idx_ff;

   // Query operands.
   logic signed [sbo_pkg::COORD_W-1:0] qa_ff [sbo_pkg::NUM_AXES];
   logic signed [sbo_pkg::DIFF_W-1:0]  qd_ff [sbo_pkg::NUM_AXES];

   // Length test.
   logic [2:0]  lstep_ff;
   logic [61:0] prod_ff;
   logic [63:0] acc_ff;

   // Per-box slab state.
   logic [AXIS_W-1:0]                  axis_ff;
   logic                               half_ff;
   logic signed [sbo_pkg::EDGE_W-1:0]  hi_ff;
   logic signed [sbo_pkg::QUOT_W-1:0]  t1_ff;
   logic signed [sbo_pkg::QUOT_W-1:0]  tmin_ff;
   logic signed [sbo_pkg::QUOT_W-1:0]  tmax_ff;
   logic                               bounded_ff;

   // Shared divider.
   logic [sbo_pkg::NUM_W-1:0]    num_ff;
   logic [sbo_pkg::DMAG_W-1:0]   rem_ff;
   logic [sbo_pkg::DMAG_W-1:0]   dmag_ff;
   logic                         neg_ff;
   logic [sbo_pkg::DSTEP_W-1:0]  dstep_ff;

   logic rsp_valid_ff;
   logic hit_ff;

   // Request field views.
   logic signed [sbo_pkg::COORD_W-1:0] in_a [sbo_pkg::NUM_AXES];
   logic signed [sbo_pkg::COORD_W-1:0] in_b [sbo_pkg::NUM_AXES];
   logic                               accept;
   logic                               add_ok;

   always_comb begin
      for (int i = 0; i < sbo_pkg::NUM_AXES; i++) begin
         in_a[i] = req_tdata[i*sbo_pkg::COORD_W +: sbo_pkg::COORD_W];
         in_b[i] = req_tdata[(i+3)*sbo_pkg::COORD_W +: sbo_pkg::COORD_W];
      end
   end

   assign accept = req_tvalid && req_tready;
   assign add_ok = (count_ff < sbo_pkg::CNT_W'(sbo_pkg::MAX_BOXES)) &&
                   (in_b[0] > 0) && (in_b[1] > 0) && (in_b[2] > 0);

   // Magnitudes of the segment direction and the short-segment precheck.
   logic [sbo_pkg::DMAG_W-1:0] umag [sbo_pkg::NUM_AXES];
   logic                       all_small;
   logic [sbo_pkg::MD_W-1:0]   sq_op;

   always_comb begin
      all_small = 1'b1;
      for (int i = 0; i < sbo_pkg::NUM_AXES; i++) begin
         umag[i] = qd_ff[i][sbo_pkg::DIFF_W-1] ?
                   sbo_pkg::DMAG_W'(-qd_ff[i]) : sbo_pkg::DMAG_W'(qd_ff[i]);
         if (umag[i] >= sbo_pkg::DMAG_W'(min_dist_ff)) begin
            all_small = 1'b0;
         end
      end
      case (lstep_ff)
         3'd0:    sq_op = umag[0][sbo_pkg::MD_W-1:0];
         3'd1:    sq_op = umag[1][sbo_pkg::MD_W-1:0];
         3'd2:    sq_op = umag[2][sbo_pkg::MD_W-1:0];
         default: sq_op = min_dist_ff;
      endcase
   end

   // Slab edges of the current box on the current axis.
   logic signed [sbo_pkg::COORD_W-1:0] ax_c;
   logic signed [sbo_pkg::COORD_W-1:0] ax_h;
   logic signed [sbo_pkg::COORD_W-1:0] ax_a;
   logic signed [sbo_pkg::DIFF_W-1:0]  ax_d;
   logic signed [sbo_pkg::EDGE_W-1:0]  lo_c;
   logic signed [sbo_pkg::EDGE_W-1:0]  hi_c;

   always_comb begin
      ax_c = rd_ff.center[axis_ff];
      ax_h = rd_ff.half[axis_ff];
      ax_a = qa_ff[axis_ff];
      ax_d = qd_ff[axis_ff];
      lo_c = sbo_pkg::EDGE_W'(ax_c) - sbo_pkg::EDGE_W'(ax_h) - sbo_pkg::EDGE_W'(ax_a);
      hi_c = sbo_pkg::EDGE_W'(ax_c) + sbo_pkg::EDGE_W'(ax_h) - sbo_pkg::EDGE_W'(ax_a);
   end

   // Dividend for the next division: the low edge on setup, else the high edge.
   logic signed [sbo_pkg::EDGE_W-1:0] div_src;
   logic [sbo_pkg::EMAG_W-1:0]        div_mag;

   always_comb begin
      div_src = (state_ff == ST_AXIS) ? lo_c : hi_ff;
      div_mag = div_src[sbo_pkg::EDGE_W-1] ?
                sbo_pkg::EMAG_W'(-div_src) : sbo_pkg::EMAG_W'(div_src);
   end

   // One restoring divider step and the signed quotient.
   logic [sbo_pkg::DMAG_W:0]          div_r2;
   logic [sbo_pkg::DMAG_W+1:0]        div_diff;
   logic signed [sbo_pkg::QUOT_W-1:0] quot;
   logic signed [sbo_pkg::QUOT_W-1:0] t_en;
   logic signed [sbo_pkg::QUOT_W-1:0] t_ex;

   always_comb begin
      div_r2   = {rem_ff, num_ff[sbo_pkg::NUM_W-1]};
      div_diff = {1'b0, div_r2} - {2'b00, dmag_ff};
      quot     = neg_ff ? -sbo_pkg::QUOT_W'(num_ff) : sbo_pkg::QUOT_W'(num_ff);
      t_en     = (t1_ff < quot) ? t1_ff : quot;
      t_ex     = (t1_ff < quot) ? quot : t1_ff;
   end

   // Final per-box check.
   logic box_hit;
   logic last_box;

   assign box_hit  = bounded_ff && (tmax_ff >= 0) && (tmin_ff <= tmax_ff) &&
                     (tmin_ff > sbo_pkg::QUOT_W'(near_ff)) &&
                     (tmin_ff < sbo_pkg::QUOT_W'(far_ff));
   assign last_box = (sbo_pkg::CNT_W'(idx_ff) + sbo_pkg::CNT_W'(1)) == count_ff;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= sbo_pkg::MIN_DIST_RST;
         near_ff     <= sbo_pkg::NEAR_RST;
         far_ff      <= sbo_pkg::FAR_RST;
      end else if (csr_we) begin
         case (csr_index)
            sbo_pkg::CSR_MIN_DIST: min_dist_ff <= csr_wdata;
            sbo_pkg::CSR_NEAR:     near_ff     <= csr_wdata[sbo_pkg::FRAC_W-1:0];
            sbo_pkg::CSR_FAR:      far_ff      <= csr_wdata[sbo_pkg::FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // Box table: append on an accepted add, registered read at the scan index.
   always_ff @(posedge clock) begin
      if (accept && (req_tuser == sbo_pkg::KIND_ADD) && add_ok) begin
         box_mem[count_ff[sbo_pkg::IDX_W-1:0]] <=
            '{half:   {in_b[2], in_b[1], in_b[0]},
              center: {in_a[2], in_a[1], in_a[0]}};
      end
      rd_ff <= box_mem[idx_ff];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_tuser)
                     sbo_pkg::KIND_CLEAR: count_ff <= '0;
                     sbo_pkg::KIND_ADD: begin
                        if (add_ok) begin
                           count_ff <= count_ff + sbo_pkg::CNT_W'(1);
                        end
                     end
                     sbo_pkg::KIND_QUERY: begin
                        for (int i = 0; i < sbo_pkg::NUM_AXES; i++) begin
                           qa_ff[i] <= in_a[i];
                           qd_ff[i] <= sbo_pkg::DIFF_W'(in_b[i]) -
                                       sbo_pkg::DIFF_W'(in_a[i]);
                        end
                        lstep_ff <= '0;
                        acc_ff   <= '0;
                        state_ff <= ST_LEN;
                     end
                     default: ;
                  endcase
               end
            end

            // Squares of the three direction terms, then of the minimum length.
            ST_LEN: begin
               prod_ff <= 62'(sq_op) * 62'(sq_op);
               if (lstep_ff != 3'd0) begin
                  acc_ff <= acc_ff + 64'(prod_ff);
               end
               if (lstep_ff == 3'd4) begin
                  if ((all_small && (acc_ff < 64'(prod_ff))) || (count_ff == '0)) begin
                     hit_ff       <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     idx_ff   <= '0;
                     state_ff <= ST_BOX_RD;
                  end
               end else begin
                  lstep_ff <= lstep_ff + 3'd1;
               end
            end

            ST_BOX_RD: begin
               axis_ff    <= '0;
               bounded_ff <= 1'b0;
               state_ff   <= ST_AXIS;
            end

            // Parallel axes are decided here; others start the low-edge division.
            ST_AXIS: begin
               if (ax_d == '0) begin
                  if ((lo_c < 0) && (hi_c > 0)) begin
                     if (axis_ff == AXIS_W'(sbo_pkg::NUM_AXES - 1)) begin
                        state_ff <= ST_BOX_END;
                     end else begin
                        axis_ff <= axis_ff + AXIS_W'(1);
                     end
                  end else if (last_box) begin
                     hit_ff       <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_RESP;
                  end else begin
                     idx_ff   <= idx_ff + sbo_pkg::IDX_W'(1);
                     state_ff <= ST_BOX_RD;
                  end
               end else begin
                  hi_ff    <= hi_c;
                  dmag_ff  <= ax_d[sbo_pkg::DIFF_W-1] ?
                              sbo_pkg::DMAG_W'(-ax_d) : sbo_pkg::DMAG_W'(ax_d);
                  num_ff   <= {div_mag, sbo_pkg::FRAC_SH'(0)};
                  neg_ff   <= div_src[sbo_pkg::EDGE_W-1] ^ ax_d[sbo_pkg::DIFF_W-1];
                  rem_ff   <= '0;
                  dstep_ff <= '0;
                  half_ff  <= 1'b0;
                  state_ff <= ST_DIV;
               end
            end

            // One quotient bit per cycle.
            ST_DIV: begin
               if (!div_diff[sbo_pkg::DMAG_W+1]) begin
                  rem_ff <= div_diff[sbo_pkg::DMAG_W-1:0];
                  num_ff <= {num_ff[sbo_pkg::NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= div_r2[sbo_pkg::DMAG_W-1:0];
                  num_ff <= {num_ff[sbo_pkg::NUM_W-2:0], 1'b0};
               end
               if (dstep_ff == sbo_pkg::DSTEP_W'(sbo_pkg::NUM_W - 1)) begin
                  state_ff <= ST_DIV_END;
               end else begin
                  dstep_ff <= dstep_ff + sbo_pkg::DSTEP_W'(1);
               end
            end

            // Keep the low-edge quotient, or merge both into the bounds.
            ST_DIV_END: begin
               if (!half_ff) begin
                  t1_ff    <= quot;
                  num_ff   <= {div_mag, sbo_pkg::FRAC_SH'(0)};
                  neg_ff   <= div_src[sbo_pkg::EDGE_W-1] ^ ax_d[sbo_pkg::DIFF_W-1];
                  rem_ff   <= '0;
                  dstep_ff <= '0;
                  half_ff  <= 1'b1;
                  state_ff <= ST_DIV;
               end else begin
                  bounded_ff <= 1'b1;
                  if (!bounded_ff || (t_en > tmin_ff)) begin
                     tmin_ff <= t_en;
                  end
                  if (!bounded_ff || (t_ex < tmax_ff)) begin
                     tmax_ff <= t_ex;
                  end
                  if (axis_ff == AXIS_W'(sbo_pkg::NUM_AXES - 1)) begin
                     state_ff <= ST_BOX_END;
                  end else begin
                     axis_ff  <= axis_ff + AXIS_W'(1);
                     state_ff <= ST_AXIS;
                  end
               end
            end

            ST_BOX_END: begin
               if (box_hit || last_box) begin
                  hit_ff       <= box_hit;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_RESP;
               end else begin
                  idx_ff   <= idx_ff + sbo_pkg::IDX_W'(1);
                  state_ff <= ST_BOX_RD;
               end
            end

            ST_RESP: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(sbo_pkg::RSP_DATA_W - 1)'(0), hit_ff};

   // The answer is shown exactly while the sequencer waits for its transfer.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_RESP))
      else $error("response valid out of step with the sequencer");

   // The fill count never passes the table depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sbo_pkg::CNT_W'(sbo_pkg::MAX_BOXES))
      else $error("box count beyond table depth");

   // The scan only reads entries that were written.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BOX_RD) |-> (sbo_pkg::CNT_W'(idx_ff) < count_ff))
      else $error("scan index beyond box count");

   // The divider never runs on a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dmag_ff != '0))
      else $error("division by zero direction");

   // A clear empties the table at once.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == sbo_pkg::KIND_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the table");

endmodule

// ===== tb/sv/segment_box_occlusion_test_test.sv =====
// Testbench for the segment versus box occlusion test, with a scoreboard that predicts each hit.
module segment_box_occlusion_test_test;

   localparam logic [1:0] CSR_SPARE = 2'd3;   // index past the register list
   localparam logic [1:0] KIND_SPARE = 2'd3;  // unknown kind, ignored by the block
   localparam int WATCH_LIMIT = 40000;
   localparam int LONG_HOLD = 3000;

   // Tracks the box table and the registers, and holds the hit flags still owed.
   class hit_scoreboard;
      int cx[sbo_pkg::MAX_BOXES], cy[sbo_pkg::MAX_BOXES], cz[sbo_pkg::MAX_BOXES];
      int hx[sbo_pkg::MAX_BOXES], hy[sbo_pkg::MAX_BOXES], hz[sbo_pkg::MAX_BOXES];
      int count;
      longint unsigned min_dist;
      longint near_frac, far_frac;
      bit hits_owed[$];
      int errors;

      function new();
         count = 0;
         min_dist = 256;
         near_frac = 655;
         far_frac = 64881;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [sbo_pkg::CSR_W-1:0] val);
         case (idx)
            sbo_pkg::CSR_MIN_DIST: min_dist = val[sbo_pkg::MD_W-1:0];
            sbo_pkg::CSR_NEAR:     near_frac = val[sbo_pkg::FRAC_W-1:0];
            sbo_pkg::CSR_FAR:      far_frac = val[sbo_pkg::FRAC_W-1:0];
            default: ;
         endcase
      endfunction

      // One slab; returns 0 when this axis rules the box out.
      function bit slab(longint c, longint h, longint a, longint d, inout bit bounded,
                        inout longint tmin, inout longint tmax);
         longint lo, hi, t1, t2, en, ex;
         lo = c - h - a;
         hi = c + h - a;
         if (d == 0) return (lo < 0) && (hi > 0);
         t1 = (lo * 65536) / d;
         t2 = (hi * 65536) / d;
         en = (t1 < t2) ? t1 : t2;
         ex = (t1 < t2) ? t2 : t1;
         if (!bounded) begin
            bounded = 1;
            tmin = en;
            tmax = ex;
         end else begin
            if (en > tmin) tmin = en;
            if (ex < tmax) tmax = ex;
         end
         return 1;
      endfunction

      function bit segment_hit(longint ax, longint ay, longint az,
                               longint bx, longint by, longint bz);
         longint dx, dy, dz, tmin, tmax;
         longint unsigned ux, uy, uz;
         bit bounded;
         dx = bx - ax;
         dy = by - ay;
         dz = bz - az;
         ux = (dx < 0) ? -dx : dx;
         uy = (dy < 0) ? -dy : dy;
         uz = (dz < 0) ? -dz : dz;
         if (ux < min_dist && uy < min_dist && uz < min_dist)
            if (ux * ux + uy * uy + uz * uz < min_dist * min_dist) return 0;
         for (int i = 0; i < count; i++) begin
            bounded = 0;
            tmin = 0;
            tmax = 0;
            if (!slab(cx[i], hx[i], ax, dx, bounded, tmin, tmax)) continue;
            if (!slab(cy[i], hy[i], ay, dy, bounded, tmin, tmax)) continue;
            if (!slab(cz[i], hz[i], az, dz, bounded, tmin, tmax)) continue;
            if (!bounded) continue;
            if (tmax < 0 || tmin > tmax) continue;
            if (tmin > near_frac && tmin < far_frac) return 1;
         end
         return 0;
      endfunction

      // Called for every accepted request transfer.
      function void note_request(logic [1:0] kind, logic [sbo_pkg::REQ_DATA_W-1:0] data);
         int f[6];
         for (int k = 0; k < 6; k++) f[k] = data[k*sbo_pkg::COORD_W +: sbo_pkg::COORD_W];
         case (kind)
            sbo_pkg::KIND_CLEAR: count = 0;
            sbo_pkg::KIND_ADD:
               if (count < sbo_pkg::MAX_BOXES && f[3] > 0 && f[4] > 0 && f[5] > 0) begin
                  cx[count] = f[0]; cy[count] = f[1]; cz[count] = f[2];
                  hx[count] = f[3]; hy[count] = f[4]; hz[count] = f[5];
                  count++;
               end
            sbo_pkg::KIND_QUERY:
               hits_owed.insert(hits_owed.size(),
                                segment_hit(f[0], f[1], f[2], f[3], f[4], f[5]));
            default: ;
         endcase
      endfunction

      // Called for every accepted response transfer.
      function void check_response(logic [sbo_pkg::RSP_DATA_W-1:0] data);
         bit want;
         if (hits_owed.size() == 0) begin
            $error("response transfer with no query waiting: tdata %h", data);
            errors++;
            return;
         end
         want = hits_owed.pop_front();
         if (data[0] !== want) begin
            $error("hit: expected %0d, actual %0d", want, data[0]);
            errors++;
         end
         if (data[sbo_pkg::RSP_DATA_W-1:1] !== '0) begin
            $error("pad: expected 0, actual %h", data[sbo_pkg::RSP_DATA_W-1:1]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [sbo_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [sbo_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [sbo_pkg::CSR_W-1:0] csr_wdata = '0;

   hit_scoreboard sb = new();
   bit no_gaps = 0;
   bit stall_start = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int lcx, lcy, lcz, lhx, lhy, lhz;   // last box added, used to aim queries

   segment_box_occlusion_test uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Mostly short gaps, now and then a long one.
   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps) return 0;
      if (r < 40) return 0;
      if (r < 80) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item and wait for its transfer.
   task send(logic [1:0] kind, int ax, int ay, int az, int bx, int by, int bz);
      int g;
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {bz, by, bx, az, ay, ax};
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, {bz, by, bx, az, ay, ax});
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task add_box(int cx, int cy, int cz, int hx, int hy, int hz);
      lcx = cx; lcy = cy; lcz = cz; lhx = hx; lhy = hy; lhz = hz;
      send(sbo_pkg::KIND_ADD, cx, cy, cz, hx, hy, hz);
   endtask

   // Stop offering, wait for every answer, then let the block settle before a register write.
   task settle();
      req_tvalid <= 0;
      while (sb.hits_owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [sbo_pkg::CSR_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task set_regs(logic [sbo_pkg::CSR_W-1:0] md, logic [sbo_pkg::CSR_W-1:0] nf,
                 logic [sbo_pkg::CSR_W-1:0] ff);
      settle();
      write_csr(sbo_pkg::CSR_MIN_DIST, md);
      write_csr(sbo_pkg::CSR_NEAR, nf);
      write_csr(sbo_pkg::CSR_FAR, ff);
   endtask

   // Small coordinates most of the time, full-width values now and then.
   function int coord();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 60000) - 30000;
   endfunction

   function int half_extent();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return -$urandom_range(0, 1000);
      if (r == 1) return 0;
      if (r == 2) return $urandom_range(1, 32'h7fff_ffff);
      return $urandom_range(50, 6000);
   endfunction

   // Pick the two ends of one axis, aimed at the last box most of the time.
   task aim_axis(int c, int h, output int a, output int b);
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         a = coord();
         b = coord();
      end else if (r < 3) begin
         a = c + $urandom_range(0, 2 * h) - h;
         b = a;
      end else begin
         a = c - $urandom_range(0, 4 * h + 400) - 1;
         b = c + $urandom_range(0, 4 * h + 400) + 1;
         if ($urandom_range(0, 1)) begin
            r = a; a = b; b = r;
         end
      end
   endtask

   task random_query();
      int ax, ay, az, bx, by, bz;
      aim_axis(lcx, lhx, ax, bx);
      aim_axis(lcy, lhy, ay, by);
      aim_axis(lcz, lhz, az, bz);
      send(sbo_pkg::KIND_QUERY, ax, ay, az, bx, by, bz);
   endtask

   // A table of a few boxes followed by queries, with some stray items mixed in.
   task random_run(int items);
      int n, r;
      n = 0;
      while (n < items) begin
         send(sbo_pkg::KIND_CLEAR, coord(), coord(), coord(), coord(), coord(), coord());
         n++;
         repeat ($urandom_range(1, 5)) begin
            add_box(coord(), coord(), coord(), half_extent(), half_extent(), half_extent());
            n++;
         end
         repeat ($urandom_range(2, 6)) begin
            r = $urandom_range(0, 19);
            if (r == 0) send(KIND_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom);
            else if (r == 1) send(sbo_pkg::KIND_QUERY, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
            else random_query();
            n++;
         end
      end
   endtask

   // Sample and check responses; drive the receiver's ready with random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (stall_start) begin
         stall_start = 0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if ($urandom_range(0, 99) < 8) begin
         hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("segment_box_occlusion_test_test failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed items under the reset register values.
      send(sbo_pkg::KIND_QUERY, -1000, 0, 0, 1000, 0, 0);         // empty table
      add_box(0, 0, 0, 256, 256, 256);
      send(sbo_pkg::KIND_QUERY, -1000, 0, 0, 1000, 0, 0);         // parallel y and z inside
      send(sbo_pkg::KIND_QUERY, -1000, 0, 0, -900, 0, 0);         // short segment
      send(sbo_pkg::KIND_QUERY, -1000, 256, 0, 1000, 256, 0);     // parallel on slab edge
      send(sbo_pkg::KIND_QUERY, -1000, -700, 300, 1000, 700, -300);
      send(sbo_pkg::KIND_QUERY, 1000, 1000, 1000, -1000, -1000, -1000);
      add_box(5000, 5000, 5000, 0, 100, 100);                     // zero half size
      add_box(5000, 5000, 5000, 100, -1, 100);                    // negative half size
      send(sbo_pkg::KIND_QUERY, 5000, 5000, 0, 5000, 5000, 10000); // would hit only those
      send(KIND_SPARE, -1, -1, -1, -1, -1, -1);
      add_box(32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 1);
      send(sbo_pkg::KIND_QUERY, 32'h8000_0000, 32'h7fff_ffff, -5, 32'h7fff_ffff,
           32'h8000_0000, 5);
      send(sbo_pkg::KIND_QUERY, -1, -1, -1, 0, 0, 0);
      send(sbo_pkg::KIND_CLEAR, -1, -1, -1, -1, -1, -1);
      send(sbo_pkg::KIND_QUERY, -1000, 0, 0, 1000, 0, 0);         // cleared table

      // Widest fraction window and no length limit: a zero-length segment is all parallel.
      set_regs(0, 0, 65536);
      write_csr(CSR_SPARE, '1);
      add_box(0, 0, 0, 500, 500, 500);
      send(sbo_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0);
      send(sbo_pkg::KIND_QUERY, 0, 0, -400, 0, 0, 400);           // entry before the start
      send(sbo_pkg::KIND_QUERY, 0, 0, -2000, 0, 0, 2000);
      random_run(25);

      // Receiver holds off while the sender keeps offering items.
      settle();
      stall_start = 1;
      random_run(10);

      set_regs(32'h7fff_ffff, 655, 64881);
      random_run(15);
      set_regs(100, 65536, 0);
      random_run(10);
      set_regs(512, 1000, 60000);
      random_run(20);
      set_regs(256, 655, 64881);
      random_run(20);

      // Clear, add and query back to back.
      settle();
      no_gaps = 1;
      send(sbo_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0);
      add_box(0, 0, 0, 1000, 1000, 1000);
      send(sbo_pkg::KIND_QUERY, 0, 0, -3000, 0, 0, 3000);
      no_gaps = 0;

      req_tvalid <= 0;
      settle();
      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.hits_owed.size() == 0) begin
         $display("segment_box_occlusion_test_test passed");
      end else begin
         $display("segment_box_occlusion_test_test failed");
      end
      $finish;
   end
endmodule
